// ===== rtl/slm_pkg.sv =====
package slm_pkg;

  // Default sizes of the list stores
  localparam int unsigned LIST_DEPTH_DEF = 32;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // Fixed widths of the request fields
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned FIELD_W = 32;

  // Function codes of an input request
  localparam logic [FUNC_W-1:0] FUNC_APPEND_FIRST  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND_SECOND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_START         = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic append;  // write the request value into the selected list
    logic start;   // rewind both read pointers
    logic emit;    // take the smaller head, load the output register
  } slm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;     // both lists hold no element
    logic last;      // the current pick is the final one of the run
    logic out_busy;  // output register holds a request that is not taken
  } slm_status_t;

endpackage

// ===== rtl/slm_in_if.sv =====
interface slm_in_if;
  import slm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic signed [FIELD_W-1:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink (input valid, input func, input value, output ready);

endinterface

// ===== rtl/slm_out_if.sv =====
interface slm_out_if;
  import slm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] merged_value;
  logic                      is_last;

  modport source (output valid, output merged_value, output is_last, input ready);
  modport sink (input valid, input merged_value, input is_last, output ready);

endinterface

// ===== rtl/slm_ram.sv =====
module slm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/slm_ctrl.sv =====
module slm_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [slm_pkg::FUNC_W-1:0] in_func_i,
  output logic                      in_ready_o,
  input  slm_pkg::slm_status_t      status_i,
  output slm_pkg::slm_cmd_t         cmd_o
);
  import slm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Decode commands
  assign cmd_o.append = accept && (in_func_i inside {FUNC_APPEND_FIRST, FUNC_APPEND_SECOND});
  assign cmd_o.start  = accept && (in_func_i == FUNC_START) && !status_i.empty;
  assign cmd_o.emit   = (state_q == ST_EMIT) && !status_i.out_busy;

  // Advance the merge sequence
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.start) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd_o.emit) begin
          state_d = status_i.last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Input is taken only while no merge runs
  a_no_accept_in_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !(cmd_o.append || cmd_o.start))
    else $error("request accepted during a merge");

  // A start always leads to a read cycle before the first emit
  a_start_then_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == ST_READ) && !cmd_o.emit)
    else $error("start did not enter the read cycle");

  // After the final emit the controller returns to idle
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit && status_i.last) |=> (state_q == ST_IDLE))
    else $error("merge did not end after the final element");

endmodule

// ===== rtl/slm_datapath.sv =====
module slm_datapath #(
  parameter int unsigned LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = slm_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  slm_pkg::slm_cmd_t                 cmd_i,
  output slm_pkg::slm_status_t              status_o,
  input  logic [slm_pkg::FUNC_W-1:0]        in_func_i,
  input  logic signed [slm_pkg::FIELD_W-1:0] in_value_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [slm_pkg::FIELD_W-1:0] out_value_o,
  output logic                              out_last_o
);
  import slm_pkg::*;

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned TW = $clog2(2 * LIST_DEPTH + 1);

  logic [CW-1:0] first_cnt_q, first_cnt_d, second_cnt_q, second_cnt_d;
  logic [CW-1:0] first_ptr_q, first_ptr_d, second_ptr_q, second_ptr_d;
  logic          out_valid_q;
  logic signed [FIELD_W-1:0] out_value_q;
  logic          out_last_q;

  logic signed [DATA_WIDTH-1:0] wr_word;
  logic [DATA_WIDTH-1:0]        first_rd, second_rd;
  logic signed [DATA_WIDTH-1:0] pick;
  logic          sel_second, first_full, second_full;
  logic          first_we, second_we;
  logic          first_avail, second_avail, take_first;
  logic [TW-1:0] total, used;

  // Size the incoming element to the stored word
  assign wr_word    = DATA_WIDTH'(in_value_i);
  assign sel_second = (in_func_i == FUNC_APPEND_SECOND);
  assign first_full  = (first_cnt_q == CW'(LIST_DEPTH));
  assign second_full = (second_cnt_q == CW'(LIST_DEPTH));
  assign first_we    = cmd_i.append && !sel_second && !first_full;
  assign second_we   = cmd_i.append && sel_second && !second_full;

  slm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(LIST_DEPTH)) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (first_we),
    .waddr_i (first_cnt_q[AW-1:0]),
    .wdata_i (wr_word),
    .raddr_i (first_ptr_q[AW-1:0]),
    .rdata_o (first_rd)
  );

  slm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(LIST_DEPTH)) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (second_we),
    .waddr_i (second_cnt_q[AW-1:0]),
    .wdata_i (wr_word),
    .raddr_i (second_ptr_q[AW-1:0]),
    .rdata_o (second_rd)
  );

  // Pick the smaller head; ties go to the second list
  assign first_avail  = (first_ptr_q < first_cnt_q);
  assign second_avail = (second_ptr_q < second_cnt_q);
  assign take_first   = first_avail &&
                        (!second_avail || ($signed(first_rd) < $signed(second_rd)));
  assign pick         = take_first ? $signed(first_rd) : $signed(second_rd);

  assign total = TW'(first_cnt_q) + TW'(second_cnt_q);
  assign used  = TW'(first_ptr_q) + TW'(second_ptr_q) + TW'(1);

  assign status_o.empty    = (total == '0);
  assign status_o.last     = (used == total);
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  // Update counts and pointers
  always_comb begin
    first_cnt_d  = first_cnt_q;
    second_cnt_d = second_cnt_q;
    first_ptr_d  = first_ptr_q;
    second_ptr_d = second_ptr_q;
    if (first_we) begin
      first_cnt_d = first_cnt_q + CW'(1);
    end
    if (second_we) begin
      second_cnt_d = second_cnt_q + CW'(1);
    end
    if (cmd_i.start) begin
      first_ptr_d  = '0;
      second_ptr_d = '0;
    end
    if (cmd_i.emit) begin
      if (take_first) begin
        first_ptr_d = first_ptr_q + CW'(1);
      end else begin
        second_ptr_d = second_ptr_q + CW'(1);
      end
      if (status_o.last) begin
        first_cnt_d  = '0;
        second_cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      first_ptr_q  <= '0;
      second_ptr_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      first_cnt_q  <= first_cnt_d;
      second_cnt_q <= second_cnt_d;
      first_ptr_q  <= first_ptr_d;
      second_ptr_q <= second_ptr_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Hold the result request until taken
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q <= FIELD_W'($unsigned(pick));
      out_last_q  <= status_o.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

  // Counts never pass the list depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (first_cnt_q <= CW'(LIST_DEPTH)) && (second_cnt_q <= CW'(LIST_DEPTH)))
    else $error("list count beyond depth");

  // An emit always has an element left to take
  a_emit_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (first_avail || second_avail))
    else $error("emit with both lists exhausted");

  // An emit never overwrites a pending result
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !(out_valid_q && !out_ready_i))
    else $error("pending result overwritten");

  // The final emit clears both counts
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && status_o.last) |=> (first_cnt_q == '0) && (second_cnt_q == '0))
    else $error("counts not cleared after merge");

endmodule

// ===== rtl/sorted_list_merge.sv =====
// Appends are stored on acceptance; in ready is high whenever no merge runs.
// A start request with N stored elements runs one round per result: a read
// state of the list RAMs, then a compare/emit state, each round finished before
// the next begins; a stalled output holds the emit state. In ready stays low
// from the start request until the final result is registered.
// Reset clears counts, pointers and control; list contents are left undefined.
module sorted_list_merge #(
  parameter int unsigned LIST_DEPTH = slm_pkg::LIST_DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = slm_pkg::DATA_WIDTH_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  slm_in_if.sink     req_i,
  slm_out_if.source  rsp_o
);
  import slm_pkg::*;

  slm_cmd_t    cmd;
  slm_status_t status;

  slm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_func_i  (req_i.func),
    .in_ready_o (req_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  slm_datapath #(
    .LIST_DEPTH (LIST_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_func_i   (req_i.func),
    .in_value_i  (req_i.value),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .out_value_o (rsp_o.merged_value),
    .out_last_o  (rsp_o.is_last)
  );

endmodule

// ===== tb/sv/sorted_list_merge_tb.sv =====
module sorted_list_merge_tb;
  import slm_pkg::*;

  localparam int unsigned DEPTH = LIST_DEPTH_DEF;
  localparam int unsigned DW    = DATA_WIDTH_DEF;

  // Code that the block must ignore
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Value patterns for a list pair
  localparam int MODE_WIDE     = 0;
  localparam int MODE_TIES     = 1;
  localparam int MODE_UNSORTED = 2;

  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned STALL_CYCLES   = 400;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned RANDOM_ITEMS   = 180;

  localparam logic signed [FIELD_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [FIELD_W-1:0] WORD_MAX = 32'sh7fff_ffff;

  // Keeps both lists and the merged sequence they must produce
  class merge_scoreboard;
    logic [DW-1:0]      first_list[$];
    logic [DW-1:0]      second_list[$];
    logic [FIELD_W-1:0] exp_value[$];
    logic               exp_last[$];
    int                 errors;

    // Apply an accepted request to the list state
    function void note_request(input logic [FUNC_W-1:0] func,
                               input logic [FIELD_W-1:0] value);
      int            a;
      int            b;
      int            total;
      logic          take_first;
      logic [DW-1:0] pick;
      a = 0;
      b = 0;
      case (func)
        FUNC_APPEND_FIRST: begin
          if (first_list.size() < DEPTH) first_list.push_back(DW'(value));
        end
        FUNC_APPEND_SECOND: begin
          if (second_list.size() < DEPTH) second_list.push_back(DW'(value));
        end
        FUNC_START: begin
          total = first_list.size() + second_list.size();
          for (int n = 0; n < total; n++) begin
            // first list wins only when strictly smaller, ties go to second
            if (a < first_list.size() && b < second_list.size())
              take_first = $signed(first_list[a]) < $signed(second_list[b]);
            else
              take_first = (a < first_list.size());
            if (take_first) begin
              pick = first_list[a];
              a++;
            end else begin
              pick = second_list[b];
              b++;
            end
            exp_value.push_back(FIELD_W'(pick));
            exp_last.push_back(n == total - 1);
          end
          first_list.delete();
          second_list.delete();
        end
        default: ;
      endcase
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(input logic [FIELD_W-1:0] value, input logic is_last);
      logic [FIELD_W-1:0] want_value;
      logic               want_last;
      if (exp_value.size() == 0) begin
        $error("unexpected result: merged_value %0d, is_last %0b", $signed(value), is_last);
        errors++;
        return;
      end
      want_value = exp_value.pop_front();
      want_last  = exp_last.pop_front();
      if (value !== want_value) begin
        $error("merged_value: expected %0d, actual %0d", $signed(want_value), $signed(value));
        errors++;
      end
      if (is_last !== want_last) begin
        $error("is_last: expected %0b, actual %0b", want_last, is_last);
        errors++;
      end
    endfunction

    function int pending();
      return exp_value.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  slm_in_if  req_if ();
  slm_out_if rsp_if ();

  sorted_list_merge u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  merge_scoreboard sb;
  int unsigned     send_idle_pct;
  int unsigned     recv_idle_pct;
  int unsigned     stall_left;
  bit              stall_armed;
  int unsigned     random_count;
  int unsigned     cycle_count;

  // Clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Drive the output ready, with one long hold-off on demand
  always @(negedge clk) begin
    if (stall_left > 0) begin
      rsp_if.ready = 1'b0;
      stall_left--;
    end else begin
      rsp_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && rsp_if.valid && rsp_if.ready)
      sb.check_result(rsp_if.merged_value, rsp_if.is_last);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Offer one request, with random idle cycles in front, and wait for acceptance
  task automatic send_req(input logic [FUNC_W-1:0] func,
                          input logic signed [FIELD_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.func  = func;
    req_if.value = value;
    do @(posedge clk); while (!req_if.ready);
    sb.note_request(func, value);
    if (stall_armed) begin
      stall_left  = STALL_CYCLES;
      stall_armed = 1'b0;
    end
    @(negedge clk);
  endtask

  function automatic logic signed [FIELD_W-1:0] rand_word(input int mode);
    if (mode == MODE_TIES) return $signed($urandom_range(15)) - 8;
    case ($urandom_range(15))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      default: return $urandom;
    endcase
  endfunction

  // Load two lists, interleaving the appends and some ignored codes, then merge
  task automatic send_group(input int nf, input int ns, input int mode);
    int qa[$];
    int qb[$];
    int ia;
    int ib;
    ia = 0;
    ib = 0;
    for (int k = 0; k < nf; k++) qa.push_back(rand_word(mode));
    for (int k = 0; k < ns; k++) qb.push_back(rand_word(mode));
    if (mode != MODE_UNSORTED) begin
      qa.sort();
      qb.sort();
    end
    while (ia < nf || ib < ns) begin
      if ($urandom_range(19) == 0) send_req(FUNC_UNUSED, $urandom);
      if (ib >= ns || (ia < nf && $urandom_range(1) == 1)) begin
        send_req(FUNC_APPEND_FIRST, qa[ia]);
        ia++;
      end else begin
        send_req(FUNC_APPEND_SECOND, qb[ib]);
        ib++;
      end
    end
    send_req(FUNC_START, $urandom);
    random_count += nf + ns + 1;
  endtask

  // Pick list sizes, mostly short, now and then past capacity
  task automatic send_random_group();
    int roll;
    int mode;
    roll = $urandom_range(99);
    mode = ($urandom_range(9) < 7) ? MODE_WIDE :
           ($urandom_range(1) == 1) ? MODE_TIES : MODE_UNSORTED;
    if (roll < 75)
      send_group($urandom_range(6), $urandom_range(6), mode);
    else if (roll < 95)
      send_group($urandom_range(16), $urandom_range(16), mode);
    else
      send_group($urandom_range(35, 30), $urandom_range(35, 30), mode);
  endtask

  task automatic run_directed();
    // start with nothing stored
    send_req(FUNC_START, $urandom);
    // extremes in both lists, ties at both ends
    send_req(FUNC_APPEND_FIRST, WORD_MIN);
    send_req(FUNC_APPEND_FIRST, 0);
    send_req(FUNC_APPEND_FIRST, WORD_MAX);
    send_req(FUNC_APPEND_SECOND, WORD_MIN);
    send_req(FUNC_APPEND_SECOND, 5);
    send_req(FUNC_APPEND_SECOND, WORD_MAX);
    send_req(FUNC_START, $urandom);
    // first list loaded out of order
    send_req(FUNC_APPEND_SECOND, -1);
    send_req(FUNC_APPEND_FIRST, 10);
    send_req(FUNC_APPEND_FIRST, -3);
    send_req(FUNC_APPEND_SECOND, 4);
    send_req(FUNC_START, $urandom);
    // only the second list, then a single element in the first
    send_req(FUNC_APPEND_SECOND, 7);
    send_req(FUNC_APPEND_SECOND, 8);
    send_req(FUNC_START, $urandom);
    send_req(FUNC_APPEND_FIRST, 1);
    send_req(FUNC_START, $urandom);
    // unused code alone, then mixed with a load
    send_req(FUNC_UNUSED, 32'h5a5a_5a5a);
    send_req(FUNC_START, $urandom);
    send_req(FUNC_UNUSED, 32'ha5a5_a5a5);
    send_req(FUNC_APPEND_FIRST, 2);
    send_req(FUNC_START, $urandom);
  endtask

  initial begin
    sb            = new;
    send_idle_pct = 34;
    recv_idle_pct = 46;
    stall_left    = 0;
    stall_armed   = 1'b0;
    random_count  = 0;
    cycle_count   = 0;
    req_if.valid  = 1'b0;
    req_if.func   = FUNC_APPEND_FIRST;
    req_if.value  = '0;
    rsp_if.ready  = 1'b0;
    rst_n         = 1'b0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    run_directed();

    // receiver idles more than sender; overfill both lists first
    send_group(35, 33, MODE_WIDE);
    while (random_count < RANDOM_ITEMS / 3) send_random_group();

    // sender idles more than receiver
    send_idle_pct = 46;
    recv_idle_pct = 34;
    while (random_count < 2 * RANDOM_ITEMS / 3) send_random_group();

    // no idling; hold the output off while two full lists are merged
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_armed   = 1'b1;
    send_group(32, 32, MODE_WIDE);
    while (random_count < RANDOM_ITEMS) send_random_group();
    req_if.valid = 1'b0;

    // drain, then allow a few cycles for anything stray
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/slm_pkg.sv
rtl/slm_in_if.sv
rtl/slm_out_if.sv
rtl/slm_ram.sv
rtl/slm_ctrl.sv
rtl/slm_datapath.sv
rtl/sorted_list_merge.sv
tb/sv/sorted_list_merge_tb.sv
